// ===== src/utf8_byte_stream_decoder_defines.svh =====
// assertion macros shared by the utf8 byte stream decoder modules
// no dependencies; included by the files that carry assertions
`ifndef UTF8_BYTE_STREAM_DECODER_DEFINES_SVH
`define UTF8_BYTE_STREAM_DECODER_DEFINES_SVH

// expression must hold at every clock edge outside reset
`define UBSD_ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define UBSD_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/ubsd_pkg.sv =====
// shared types, constants and decode functions for the utf8 byte stream decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ubsd_pkg;

    localparam int unsigned CP_W        = 21;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [CP_W-1:0] QMARK = 21'd63;

    // sequence length codes
    localparam logic [2:0] LEN_NONE  = 3'd0;
    localparam logic [2:0] LEN_ONE   = 3'd1;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

    // one decoded job: up to three code points from a single byte
    typedef struct packed {
        logic                  fin;
        logic [1:0]            last_idx;
        logic [2:0][CP_W-1:0]  cp;
    } job_t;

    function automatic logic [2:0] lead_len(input logic [7:0] c);
        logic [2:0] len;
        if (c[7] == 1'b0) begin
            len = LEN_ONE;
        end else if (c[7:5] == 3'h6) begin
            len = LEN_TWO;
        end else if (c[7:4] == 4'hE) begin
            len = LEN_THREE;
        end else if (c[7:3] == 5'h1E) begin
            len = LEN_FOUR;
        end else begin
            len = LEN_NONE;
        end
        return len;
    endfunction

    // a byte decoded as a lone lead at the end of a text
    function automatic logic [CP_W-1:0] single(input logic [7:0] c);
        logic [CP_W-1:0] cp;
        if (c[7] == 1'b0) begin
            cp = {13'd0, c};
        end else begin
            cp = QMARK;
        end
        return cp;
    endfunction

    function automatic logic [CP_W-1:0] combine(input logic [2:0] len,
                                                input logic [7:0] h0,
                                                input logic [7:0] h1,
                                                input logic [7:0] h2,
                                                input logic [7:0] b);
        logic [CP_W-1:0] cp;
        case (len)
            LEN_TWO:   cp = {10'd0, h0[4:0], b[5:0]};
            LEN_THREE: cp = {5'd0, h0[3:0], h1[5:0], b[5:0]};
            LEN_FOUR:  cp = {h0[2:0], h1[5:0], h2[5:0], b[5:0]};
            default:   cp = QMARK;
        endcase
        return cp;
    endfunction

endpackage

`default_nettype wire

// ===== src/ubsd_front.sv =====
// front end: accepts bytes, tracks the open sequence and builds result jobs
// depends on ubsd_pkg and utf8_byte_stream_decoder_defines.svh
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_byte_stream_decoder_defines.svh"

module ubsd_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          accept,
    input  wire logic [7:0]    text_byte,
    input  wire logic          final_byte,
    output ubsd_pkg::job_t     job,
    output logic               push
);

    logic [7:0] h0_reg, h0_next;
    logic [7:0] h1_reg, h1_next;
    logic [7:0] h2_reg, h2_next;
    logic [1:0] hc_reg, hc_next;
    logic [2:0] seqlen_reg, seqlen_next;
    logic [2:0] len;

    always_comb begin
        h0_next     = h0_reg;
        h1_next     = h1_reg;
        h2_next     = h2_reg;
        hc_next     = hc_reg;
        seqlen_next = seqlen_reg;
        push        = 1'b0;
        job         = '0;
        job.fin     = final_byte;
        len         = ubsd_pkg::lead_len(text_byte);
        if (accept) begin
            if (seqlen_reg == ubsd_pkg::LEN_NONE) begin
                if (len == ubsd_pkg::LEN_ONE) begin
                    push      = 1'b1;
                    job.cp[0] = {13'd0, text_byte};
                end else if (len == ubsd_pkg::LEN_NONE || final_byte) begin
                    push      = 1'b1;
                    job.cp[0] = ubsd_pkg::QMARK;
                end else begin
                    h0_next     = text_byte;
                    hc_next     = 2'd1;
                    seqlen_next = len;
                end
            end else if (({1'b0, hc_reg} + 3'd1) >= seqlen_reg) begin
                push        = 1'b1;
                job.cp[0]   = ubsd_pkg::combine(seqlen_reg, h0_reg, h1_reg, h2_reg,
                                                text_byte);
                hc_next     = 2'd0;
                seqlen_next = ubsd_pkg::LEN_NONE;
            end else if (final_byte) begin
                // truncated sequence: lead gives '?', the rest is decoded again
                push      = 1'b1;
                job.cp[0] = ubsd_pkg::QMARK;
                if (hc_reg == 2'd1) begin
                    job.cp[1]    = ubsd_pkg::single(text_byte);
                    job.last_idx = 2'd1;
                end else if (ubsd_pkg::lead_len(h1_reg) == ubsd_pkg::LEN_TWO) begin
                    job.cp[1]    = ubsd_pkg::combine(ubsd_pkg::LEN_TWO, h1_reg, 8'd0,
                                                     8'd0, text_byte);
                    job.last_idx = 2'd1;
                end else begin
                    job.cp[1]    = ubsd_pkg::single(h1_reg);
                    job.cp[2]    = ubsd_pkg::single(text_byte);
                    job.last_idx = 2'd2;
                end
            end else begin
                case (hc_reg)
                    2'd1:    h1_next = text_byte;
                    2'd2:    h2_next = text_byte;
                    default: h0_next = text_byte;
                endcase
                hc_next = hc_reg + 2'd1;
            end
            if (final_byte) begin
                hc_next     = 2'd0;
                seqlen_next = ubsd_pkg::LEN_NONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        h0_reg <= h0_next;
        h1_reg <= h1_next;
        h2_reg <= h2_next;
        if (!aresetn) begin
            hc_reg     <= 2'd0;
            seqlen_reg <= ubsd_pkg::LEN_NONE;
        end else begin
            hc_reg     <= hc_next;
            seqlen_reg <= seqlen_next;
        end
    end

    `UBSD_ASSERT_IMPL(a_idle_no_held, aclk, aresetn, seqlen_reg == ubsd_pkg::LEN_NONE, hc_reg == 2'd0, "bytes held with no open sequence")
    `UBSD_ASSERT_IMPL(a_held_below_len, aclk, aresetn, seqlen_reg != ubsd_pkg::LEN_NONE, ({1'b0, hc_reg} < seqlen_reg) && (seqlen_reg <= ubsd_pkg::LEN_FOUR), "held count reached sequence length")

endmodule

`default_nettype wire

// ===== src/ubsd_queue.sv =====
// short job queue between the front end and the output stage
// depends on ubsd_pkg and utf8_byte_stream_decoder_defines.svh
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_byte_stream_decoder_defines.svh"

module ubsd_queue #(
    parameter int unsigned DEPTH = ubsd_pkg::QUEUE_DEPTH
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire ubsd_pkg::job_t push_job,
    output logic                not_full,
    input  wire logic           pop,
    output ubsd_pkg::job_t      head_job,
    output logic                not_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ubsd_pkg::job_t   slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign not_full  = (cnt_reg != FULL_CNT);
    assign not_empty = (cnt_reg != '0);
    assign head_job  = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    `UBSD_ASSERT_IMPL(a_no_push_full, aclk, aresetn, push, not_full,
                      "job pushed into full queue")
    `UBSD_ASSERT_IMPL(a_no_pop_empty, aclk, aresetn, pop, not_empty,
                      "job popped from empty queue")
    `UBSD_ASSERT_ALWAYS(a_cnt_range, aclk, aresetn, cnt_reg <= FULL_CNT,
                        "queue count beyond depth")

endmodule

`default_nettype wire

// ===== src/ubsd_back.sv =====
// output stage: holds one job and sends its code points one transfer at a time
// depends on ubsd_pkg and utf8_byte_stream_decoder_defines.svh
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_byte_stream_decoder_defines.svh"

module ubsd_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire ubsd_pkg::job_t head_job,
    input  wire logic           head_valid,
    output logic                pop,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [23:0]         m_tdata,
    output logic                m_tuser,
    output logic                m_tlast
);

    ubsd_pkg::job_t  job_reg, job_next;
    logic [1:0]      idx_reg, idx_next;
    logic            valid_reg, valid_next;
    logic            at_last;
    logic [ubsd_pkg::CP_W-1:0] cp_sel;

    assign at_last = (idx_reg == job_reg.last_idx);

    always_comb begin
        case (idx_reg)
            2'd1:    cp_sel = job_reg.cp[1];
            2'd2:    cp_sel = job_reg.cp[2];
            default: cp_sel = job_reg.cp[0];
        endcase
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'd0, cp_sel};
    assign m_tuser  = at_last;
    assign m_tlast  = at_last && job_reg.fin;

    always_comb begin
        job_next   = job_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        pop        = 1'b0;
        if (!valid_reg || (m_tready && at_last)) begin
            // current job done or none held: take the next one at once
            pop        = head_valid;
            job_next   = head_job;
            idx_next   = 2'd0;
            valid_next = head_valid;
        end else if (m_tready) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    `UBSD_ASSERT_IMPL(a_idx_bound, aclk, aresetn, valid_reg,
                      (idx_reg <= job_reg.last_idx) && (job_reg.last_idx != 2'd3),
                      "result index beyond job")
    `UBSD_ASSERT_IMPL(a_text_end_item_end, aclk, aresetn, m_tvalid && m_tlast, m_tuser,
                      "end of text without end of item")

endmodule

`default_nettype wire

// ===== src/utf8_byte_stream_decoder.sv =====
// utf8 byte stream decoder, top level
// depends on ubsd_pkg, ubsd_front, ubsd_queue and ubsd_back
//
// input: one byte of utf-8 text per transfer on s_tdata[7:0], s_tlast set on the
// last byte of the text. output: one code point per transfer on m_tdata[20:0],
// m_tuser set on the last code point caused by an input byte, m_tlast set on the
// final code point of the text.
// a byte that completes or ends a sequence yields one job in a short queue; a byte
// inside a sequence yields nothing. each job is written into the queue, then taken
// into the output stage register, from which its first code point is offered.
// throughput is one byte and one code point per cycle while the queue has room and
// m_tready is high; a sequence cut short by the end of the text gives up to three
// code points, sent one transfer each by the output stage.
// when m_tready is low, jobs pile up in the queue (QUEUE_DEPTH entries) and
// s_tready drops once it is full; the offered transfer holds steady.
// reset empties the queue and the output stage and drops any open sequence.
`timescale 1ns / 1ps
`default_nettype none

module utf8_byte_stream_decoder #(
    parameter int unsigned QUEUE_DEPTH = ubsd_pkg::QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
    input  wire logic        s_tlast,   // final_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [20:0] code_point, [23:21] zero
    output logic             m_tuser,   // [0] last_of_item
    output logic             m_tlast    // last_of_text
);

    ubsd_pkg::job_t push_job;
    ubsd_pkg::job_t head_job;
    logic           push;
    logic           pop;
    logic           not_full;
    logic           not_empty;
    logic           accept;

    assign s_tready = not_full;
    assign accept   = s_tvalid && not_full;

    ubsd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .text_byte  (s_tdata),
        .final_byte (s_tlast),
        .job        (push_job),
        .push       (push)
    );

    ubsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .not_full  (not_full),
        .pop       (pop),
        .head_job  (head_job),
        .not_empty (not_empty)
    );

    ubsd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_job   (head_job),
        .head_valid (not_empty),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire
